@@ rtl/dsd_pkg.sv @@
`timescale 1ns / 1ps

package dsd_pkg;

  // Number of distinct values held per list
  localparam int CAPACITY = 32;
  // Width of a fill count that can hold CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int DCNT_W   = 6;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    is_last_res;
    logic [DCNT_W-1:0]       distinct_count;
    logic                    overflowed;
  } out_item_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins_en;
    logic                    shift_en;
    logic signed [VAL_W-1:0] new_value;
  } cell_ctrl_t;

endpackage

@@ rtl/dsd_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted chain. Slots hold values in descending order,
// valid slots form a prefix. On insert a slot takes the new value or its
// upper neighbour's value; on drain it takes its lower neighbour's value.
module dsd_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dsd_pkg::cell_ctrl_t                ctrl,
  input  logic                               prev_take,
  input  logic                               prev_valid,
  input  logic signed [dsd_pkg::VAL_W-1:0]   prev_value,
  input  logic                               next_valid,
  input  logic signed [dsd_pkg::VAL_W-1:0]   next_value,
  output logic                               take,
  output logic                               match,
  output logic                               valid,
  output logic signed [dsd_pkg::VAL_W-1:0]   value
);

  logic                             valid_r;
  logic                             valid_nxt;
  logic signed [dsd_pkg::VAL_W-1:0] value_r;
  logic signed [dsd_pkg::VAL_W-1:0] value_nxt;

  // New value belongs at or above this slot
  assign take  = !valid_r || (ctrl.new_value > value_r);
  assign match = valid_r && (ctrl.new_value == value_r);
  assign valid = valid_r;
  assign value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift_en) begin
      valid_nxt = next_valid;
      value_nxt = next_value;
    end else if (ctrl.ins_en && take) begin
      // slot above also moves down: inherit its entry
      if (prev_take) begin
        valid_nxt = prev_valid;
        value_nxt = prev_value;
      end else begin
        valid_nxt = 1'b1;
        value_nxt = ctrl.new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ rtl/distinct_sort_descending_unit.sv @@
`timescale 1ns / 1ps

// Elements are taken one per cycle into a sorted insertion chain of CAPACITY cells.
// On the last request of a list the state moves to drain; the first result is then
// registered, and the N distinct values follow one per cycle (output stalls add cycles);
// the chain drains through cell 0, and input is refused until the last result is registered.
// Synchronous active-low reset empties the chain and clears count and overflow.
module distinct_sort_descending_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dsd_pkg::out_item_t  out_data
);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_DRAIN  = 2'b10
  } state_t;

  localparam logic [dsd_pkg::CNT_W-1:0] CNT_ONE  = dsd_pkg::CNT_W'(1);
  localparam logic [dsd_pkg::CNT_W-1:0] CNT_FULL = dsd_pkg::CNT_W'(dsd_pkg::CAPACITY);

  state_t                       state_r, state_nxt;
  logic [dsd_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [dsd_pkg::CNT_W-1:0]    rem_r, rem_nxt;
  logic [dsd_pkg::CNT_W-1:0]    total_r, total_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dsd_pkg::out_item_t           out_data_r, out_data_nxt;

  dsd_pkg::cell_ctrl_t                ctrl;
  logic [dsd_pkg::CAPACITY-1:0]       take_v;
  logic [dsd_pkg::CAPACITY-1:0]       match_v;
  logic [dsd_pkg::CAPACITY-1:0]       valid_v;
  logic signed [dsd_pkg::VAL_W-1:0]   value_a [dsd_pkg::CAPACITY];

  logic in_fire;
  logic dup;
  logic full;
  logic load;
  logic new_ovf;

  assign in_ready  = (state_r == ST_ACCEPT);
  assign in_fire   = in_valid && in_ready;
  assign dup       = |match_v;
  assign full      = (count_r == CNT_FULL);
  assign new_ovf   = in_fire && !dup && full;
  assign load      = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Broadcast to the chain
  assign ctrl.ins_en    = in_fire && !dup && !full;
  assign ctrl.shift_en  = load;
  assign ctrl.new_value = in_data.value;

  // Chain of cells
  for (genvar i = 0; i < dsd_pkg::CAPACITY; i++) begin : g_cell
    logic                             p_take;
    logic                             p_valid;
    logic signed [dsd_pkg::VAL_W-1:0] p_value;
    logic                             n_valid;
    logic signed [dsd_pkg::VAL_W-1:0] n_value;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_body
      assign p_take  = take_v[i-1];
      assign p_valid = valid_v[i-1];
      assign p_value = value_a[i-1];
    end

    if (i == dsd_pkg::CAPACITY - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_inner
      assign n_valid = valid_v[i+1];
      assign n_value = value_a[i+1];
    end

    dsd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_take  (p_take),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .next_valid (n_valid),
      .next_value (n_value),
      .take       (take_v[i]),
      .match      (match_v[i]),
      .valid      (valid_v[i]),
      .value      (value_a[i])
    );
  end

  // Control: fill count, drain sequencing, output register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r | new_ovf;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_ACCEPT: begin
        if (in_fire) begin
          if (ctrl.ins_en) begin
            count_nxt = count_r + CNT_ONE;
          end
          if (in_data.is_last) begin
            rem_nxt   = ctrl.ins_en ? count_r + CNT_ONE : count_r;
            total_nxt = ctrl.ins_en ? count_r + CNT_ONE : count_r;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.value_res      = value_a[0];
          out_data_nxt.is_last_res    = (rem_r == CNT_ONE);
          out_data_nxt.distinct_count = dsd_pkg::DCNT_W'(total_r);
          out_data_nxt.overflowed     = ovf_r;
          rem_nxt                     = rem_r - CNT_ONE;
          if (rem_r == CNT_ONE) begin
            // list done: ready for the next one
            state_nxt = ST_ACCEPT;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCEPT;
      count_r     <= '0;
      rem_r       <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
